FILE: design/battery_fault_supervisor_macros.svh
// Assertion macros shared by the battery fault supervisor RTL.
`ifndef BATTERY_FAULT_SUPERVISOR_MACROS_SVH
`define BATTERY_FAULT_SUPERVISOR_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define BFS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("battery_fault_supervisor: assertion failed");

// Checks a property on every rising clock edge, reset included.
`define BFS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("battery_fault_supervisor: assertion failed");

`else

`define BFS_ASSERT(lbl, clk, rst, prop)
`define BFS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: design/bfs_pkg.sv
// Package with the types and constants of the battery fault supervisor.
`default_nettype none

package bfs_pkg;

   // Field widths.
   localparam int FLAG_W = 6;
   localparam int MV_W   = 13;
   localparam int HOLD_W = 16;
   localparam int CNT_W  = 8;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Status flag bit positions.
   localparam int F_READY   = 5;
   localparam int F_ALERT   = 4;
   localparam int F_UV      = 3;
   localparam int F_OV      = 2;
   localparam int F_SHORT   = 1;
   localparam int F_OVERCUR = 0;

   // Discharge command codes.
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_ENABLE  = 2'd1,
      CMD_DISABLE = 2'd2
   } dcmd_type;

   // Configuration register indexes.
   typedef enum logic [IDX_W-1:0] {
      REG_UNDERVOLT    = 3'd0,
      REG_OVERVOLT     = 3'd1,
      REG_READY_HOLD   = 3'd2,
      REG_ALERT_HOLD   = 3'd3,
      REG_SHORT_HOLD   = 3'd4,
      REG_OVERCUR_HOLD = 3'd5,
      REG_SHORT_LIMIT  = 3'd6,
      REG_OVERCUR_LIMIT = 3'd7
   } reg_idx_type;

   // Reset values of the configuration registers.
   localparam logic [MV_W-1:0]   RST_UNDERVOLT    = 13'd3000;
   localparam logic [MV_W-1:0]   RST_OVERVOLT     = 13'd4200;
   localparam logic [HOLD_W-1:0] RST_READY_HOLD   = 16'd3000;
   localparam logic [HOLD_W-1:0] RST_ALERT_HOLD   = 16'd10000;
   localparam logic [HOLD_W-1:0] RST_SHORT_HOLD   = 16'd30000;
   localparam logic [HOLD_W-1:0] RST_OVERCUR_HOLD = 16'd10000;
   localparam logic [CNT_W-1:0]  RST_SHORT_LIMIT  = 8'd3;
   localparam logic [CNT_W-1:0]  RST_OVERCUR_LIMIT = 8'd7;

   // Full set of configuration registers.
   typedef struct packed {
      logic [MV_W-1:0]   undervolt_mv;
      logic [MV_W-1:0]   overvolt_mv;
      logic [HOLD_W-1:0] ready_hold_ms;
      logic [HOLD_W-1:0] alert_hold_ms;
      logic [HOLD_W-1:0] short_hold_ms;
      logic [HOLD_W-1:0] overcur_hold_ms;
      logic [CNT_W-1:0]  short_limit;
      logic [CNT_W-1:0]  overcur_limit;
   } cfg_type;

   // Control of one hold timer.
   typedef struct packed {
      logic step;   // a beat moves on with this timer's flag set
      logic clear;  // a beat moves on with no flag set
   } timer_ctl_type;

endpackage

`default_nettype wire

FILE: design/bfs_csr.sv
// Configuration register file of the battery fault supervisor.
`default_nettype none

module bfs_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [bfs_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [bfs_pkg::DATA_W-1:0] csr_wdata,
   output bfs_pkg::cfg_type               cfg
);
   import bfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index and update the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_UNDERVOLT:     cfg_in.undervolt_mv    = csr_wdata[MV_W-1:0];
            REG_OVERVOLT:      cfg_in.overvolt_mv     = csr_wdata[MV_W-1:0];
            REG_READY_HOLD:    cfg_in.ready_hold_ms   = csr_wdata[HOLD_W-1:0];
            REG_ALERT_HOLD:    cfg_in.alert_hold_ms   = csr_wdata[HOLD_W-1:0];
            REG_SHORT_HOLD:    cfg_in.short_hold_ms   = csr_wdata[HOLD_W-1:0];
            REG_OVERCUR_HOLD:  cfg_in.overcur_hold_ms = csr_wdata[HOLD_W-1:0];
            REG_SHORT_LIMIT:   cfg_in.short_limit     = csr_wdata[CNT_W-1:0];
            REG_OVERCUR_LIMIT: cfg_in.overcur_limit   = csr_wdata[CNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.undervolt_mv    <= RST_UNDERVOLT;
         cfg_ff.overvolt_mv     <= RST_OVERVOLT;
         cfg_ff.ready_hold_ms   <= RST_READY_HOLD;
         cfg_ff.alert_hold_ms   <= RST_ALERT_HOLD;
         cfg_ff.short_hold_ms   <= RST_SHORT_HOLD;
         cfg_ff.overcur_hold_ms <= RST_OVERCUR_HOLD;
         cfg_ff.short_limit     <= RST_SHORT_LIMIT;
         cfg_ff.overcur_limit   <= RST_OVERCUR_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/bfs_timer.sv
// Hold timer for one status flag: arms on first sight, fires after the hold.
`default_nettype none

module bfs_timer #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bfs_pkg::timer_ctl_type     ctl,
   input  wire logic [TIME_BITS-1:0]       now_ms,
   input  wire logic [bfs_pkg::HOLD_W-1:0] hold_ms,
   output logic                            fire
);
   import bfs_pkg::*;

   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] elapsed;

   // Elapsed time wraps with the time counter.
   assign elapsed = now_ms - start_ff;
   assign fire    = armed_ff && (elapsed >= TIME_BITS'(hold_ms));

   // Arm on a first flagged beat, disarm on a clear or when the hold has run out.
   always_comb begin
      armed_in = armed_ff;
      start_in = start_ff;
      if (ctl.clear) begin
         armed_in = 1'b0;
         start_in = '0;
      end else if (ctl.step) begin
         if (!armed_ff) begin
            armed_in = 1'b1;
            start_in = now_ms;
         end else if (fire) begin
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         start_ff <= '0;
      end else begin
         armed_ff <= armed_in;
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/battery_fault_supervisor.sv
// Top level of the battery fault supervisor.
//
// The block takes one poll of a battery monitor per beat on the req_ channel
// and returns one result beat per poll on the rsp_ channel, in order. A poll
// carries the six status flags, a millisecond time, the lowest and highest
// cell voltages, a connected-cell flag and the discharge switch state. The
// result carries the status bits to clear, a discharge command and the
// shutdown requests for this pack and its peer.
// A poll accepted at a clock edge is evaluated from the input register and
// moves into the result register once that register is free or being read,
// which raises rsp_valid. One poll is accepted per cycle while req_stall is
// low; the hold timers and retry counters update as the poll moves into the
// result register, so the next poll sees them at once.
// When rsp_stall is high the result register holds; a second poll may wait in
// the input register, and only then is req_stall raised.
// Limits, hold times and retry limits are written on the csr_ port, which is
// always ready. Reset loads their default values and clears all timers,
// counters and both pipeline registers.
`default_nettype none
`include "battery_fault_supervisor_macros.svh"

module battery_fault_supervisor #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Poll channel.
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [bfs_pkg::FLAG_W-1:0]  req_status_flags,
   input  wire logic [TIME_BITS-1:0]        req_now_ms,
   input  wire logic [bfs_pkg::MV_W-1:0]    req_min_cell_mv,
   input  wire logic [bfs_pkg::MV_W-1:0]    req_max_cell_mv,
   input  wire logic                        req_has_connected,
   input  wire logic                        req_discharge_on,
   // Result channel.
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [bfs_pkg::FLAG_W-1:0]       rsp_clear_mask,
   output logic [1:0]                       rsp_discharge_cmd,
   output logic                             rsp_shutdown_self,
   output logic                             rsp_shutdown_peer,
   // Configuration channel.
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bfs_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [bfs_pkg::DATA_W-1:0]  csr_wdata
);
   import bfs_pkg::*;

   cfg_type cfg;

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [FLAG_W-1:0]    flags_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [MV_W-1:0]      vmin_ff, vmax_ff;
   logic                 conn_ff, dis_on_ff;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [FLAG_W-1:0] mask_ff, mask_in;
   dcmd_type          cmd_ff, cmd_in;
   logic              shut_ff, shut_in;

   // Retry counters.
   logic [CNT_W-1:0] short_cnt_ff, short_cnt_in, short_cnt_next;
   logic [CNT_W-1:0] ovc_cnt_ff, ovc_cnt_in, ovc_cnt_next;

   logic          accept, advance, any_flag, in_limits;
   logic          fire_ready, fire_alert, fire_short, fire_ovc;
   timer_ctl_type ctl_ready, ctl_alert, ctl_short, ctl_ovc;

   bfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: the input register moves on whenever the result slot frees.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign any_flag = |flags_ff;

   // Timer controls.
   always_comb begin
      ctl_ready.step  = advance && flags_ff[F_READY];
      ctl_alert.step  = advance && flags_ff[F_ALERT];
      ctl_short.step  = advance && flags_ff[F_SHORT];
      ctl_ovc.step    = advance && flags_ff[F_OVERCUR];
      ctl_ready.clear = advance && !any_flag;
      ctl_alert.clear = advance && !any_flag;
      ctl_short.clear = advance && !any_flag;
      ctl_ovc.clear   = advance && !any_flag;
   end

   bfs_timer #(.TIME_BITS(TIME_BITS)) u_tmr_ready (
      .clock (clock), .reset (reset), .ctl (ctl_ready), .now_ms (now_ff),
      .hold_ms (cfg.ready_hold_ms), .fire (fire_ready)
   );
   bfs_timer #(.TIME_BITS(TIME_BITS)) u_tmr_alert (
      .clock (clock), .reset (reset), .ctl (ctl_alert), .now_ms (now_ff),
      .hold_ms (cfg.alert_hold_ms), .fire (fire_alert)
   );
   bfs_timer #(.TIME_BITS(TIME_BITS)) u_tmr_short (
      .clock (clock), .reset (reset), .ctl (ctl_short), .now_ms (now_ff),
      .hold_ms (cfg.short_hold_ms), .fire (fire_short)
   );
   bfs_timer #(.TIME_BITS(TIME_BITS)) u_tmr_ovc (
      .clock (clock), .reset (reset), .ctl (ctl_ovc), .now_ms (now_ff),
      .hold_ms (cfg.overcur_hold_ms), .fire (fire_ovc)
   );

   // Retry counts after this beat's clears, saturating at full scale.
   always_comb begin
      short_cnt_next = short_cnt_ff;
      ovc_cnt_next   = ovc_cnt_ff;
      if (flags_ff[F_SHORT] && fire_short && short_cnt_ff != CNT_MAX) begin
         short_cnt_next = short_cnt_ff + 1'b1;
      end
      if (flags_ff[F_OVERCUR] && fire_ovc && ovc_cnt_ff != CNT_MAX) begin
         ovc_cnt_next = ovc_cnt_ff + 1'b1;
      end
   end

   // Counters reset on a quiet poll and take their new value otherwise.
   always_comb begin
      short_cnt_in = short_cnt_ff;
      ovc_cnt_in   = ovc_cnt_ff;
      if (advance) begin
         if (!any_flag) begin
            short_cnt_in = '0;
            ovc_cnt_in   = '0;
         end else begin
            short_cnt_in = short_cnt_next;
            ovc_cnt_in   = ovc_cnt_next;
         end
      end
   end

   // Cells are in limits when none is connected or all lie inside the window.
   assign in_limits = !conn_ff ||
                      (vmin_ff >= cfg.undervolt_mv && vmax_ff <= cfg.overvolt_mv);

   // Result of the poll held in the input register.
   always_comb begin
      mask_in = '0;
      cmd_in  = CMD_NONE;
      shut_in = 1'b0;
      if (!any_flag) begin
         cmd_in = (in_limits && !dis_on_ff) ? CMD_ENABLE : CMD_NONE;
      end else begin
         cmd_in = CMD_DISABLE;
         mask_in[F_READY]   = flags_ff[F_READY] && fire_ready;
         mask_in[F_ALERT]   = flags_ff[F_ALERT] && fire_alert;
         mask_in[F_UV]      = flags_ff[F_UV] && conn_ff && (vmin_ff > cfg.undervolt_mv);
         mask_in[F_OV]      = flags_ff[F_OV] && (vmax_ff < cfg.overvolt_mv);
         mask_in[F_SHORT]   = flags_ff[F_SHORT] && fire_short;
         mask_in[F_OVERCUR] = flags_ff[F_OVERCUR] && fire_ovc;
         shut_in = (flags_ff[F_SHORT] && short_cnt_next == cfg.short_limit) ||
                   (flags_ff[F_OVERCUR] && ovc_cnt_next == cfg.overcur_limit);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         short_cnt_ff <= '0;
         ovc_cnt_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         short_cnt_ff <= short_cnt_in;
         ovc_cnt_ff   <= ovc_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff  <= req_status_flags;
         now_ff    <= req_now_ms;
         vmin_ff   <= req_min_cell_mv;
         vmax_ff   <= req_max_cell_mv;
         conn_ff   <= req_has_connected;
         dis_on_ff <= req_discharge_on;
      end
      if (advance) begin
         mask_ff <= mask_in;
         cmd_ff  <= cmd_in;
         shut_ff <= shut_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_clear_mask    = mask_ff;
   assign rsp_discharge_cmd = cmd_ff;
   assign rsp_shutdown_self = shut_ff;
   assign rsp_shutdown_peer = shut_ff;

   // An enabling result never clears bits or shuts down.
   `BFS_ASSERT(a_enable_quiet, clock, reset, (rsp_valid && cmd_ff == CMD_ENABLE) |-> (mask_ff == '0 && !shut_ff))
   // A poll only waits while a result is held back.
   `BFS_ASSERT(a_stall_cause, clock, reset, req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
   // A poll that moves on always produces a result at the next edge.
   `BFS_ASSERT(a_advance_result, clock, reset, advance |=> out_valid_ff)
   // Reset empties both pipeline registers.
   `BFS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!in_valid_ff && !out_valid_ff))

endmodule

`default_nettype wire

FILE: tb/tb_battery_fault_supervisor.sv
// Self-checking testbench for the battery fault supervisor: polls in, verdicts checked.
`timescale 1ns / 100ps

module tb_battery_fault_supervisor;
   import bfs_pkg::*;

   localparam int TIME_W      = 32;
   localparam int CYCLE_LIMIT = 200000;

   // Timer slots of the predictor.
   localparam int TMR_READY   = 0;
   localparam int TMR_ALERT   = 1;
   localparam int TMR_SHORT   = 2;
   localparam int TMR_OVERCUR = 3;

   // Flag masks for building polls: none, all and single flags.
   localparam logic [FLAG_W-1:0] FL_NONE    = '0;
   localparam logic [FLAG_W-1:0] FL_ALL     = '1;
   localparam logic [FLAG_W-1:0] FL_READY   = 6'b1 << F_READY;
   localparam logic [FLAG_W-1:0] FL_ALERT   = 6'b1 << F_ALERT;
   localparam logic [FLAG_W-1:0] FL_UV      = 6'b1 << F_UV;
   localparam logic [FLAG_W-1:0] FL_SHORT   = 6'b1 << F_SHORT;
   localparam logic [FLAG_W-1:0] FL_OVERCUR = 6'b1 << F_OVERCUR;

   typedef struct {
      logic [FLAG_W-1:0] flags;
      logic [TIME_W-1:0] now;
      logic [MV_W-1:0]   vmin;
      logic [MV_W-1:0]   vmax;
      logic              conn;
      logic              dis_on;
   } poll_type;

   typedef struct {
      logic [FLAG_W-1:0] mask;
      dcmd_type          cmd;
      logic              shut_self;
      logic              shut_peer;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FLAG_W-1:0]   req_status_flags = '0;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic [MV_W-1:0]     req_min_cell_mv = '0;
   logic [MV_W-1:0]     req_max_cell_mv = '0;
   logic                req_has_connected = 1'b0;
   logic                req_discharge_on = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [FLAG_W-1:0]   rsp_clear_mask;
   logic [1:0]          rsp_discharge_cmd;
   logic                rsp_shutdown_self;
   logic                rsp_shutdown_peer;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [DATA_W-1:0]   csr_wdata = '0;

   battery_fault_supervisor #(.TIME_BITS(TIME_W)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_status_flags  (req_status_flags),
      .req_now_ms        (req_now_ms),
      .req_min_cell_mv   (req_min_cell_mv),
      .req_max_cell_mv   (req_max_cell_mv),
      .req_has_connected (req_has_connected),
      .req_discharge_on  (req_discharge_on),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_clear_mask    (rsp_clear_mask),
      .rsp_discharge_cmd (rsp_discharge_cmd),
      .rsp_shutdown_self (rsp_shutdown_self),
      .rsp_shutdown_peer (rsp_shutdown_peer),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: configuration, hold timers and retry counters.
   cfg_type           cfg;
   bit                tmr_armed [4];
   logic [TIME_W-1:0] tmr_start [4];
   logic [CNT_W-1:0]  short_cnt;
   logic [CNT_W-1:0]  overcur_cnt;

   poll_type    polls_pending [$];
   verdict_type verdicts_due [$];
   poll_type    cur_poll;
   bit          poll_taken = 1'b0;
   bit          calm = 1'b0;
   int          err_count = 0;
   int          cycle_count = 0;

   // Stimulus generator state.
   logic [TIME_W-1:0] gen_ms = '0;
   logic [FLAG_W-1:0] gen_flags = '0;

   function automatic void clear_timers();
      for (int t = 0; t < 4; t++) begin
         tmr_armed[t] = 1'b0;
         tmr_start[t] = '0;
      end
      short_cnt   = '0;
      overcur_cnt = '0;
   endfunction

   function automatic void model_reset();
      cfg.undervolt_mv    = RST_UNDERVOLT;
      cfg.overvolt_mv     = RST_OVERVOLT;
      cfg.ready_hold_ms   = RST_READY_HOLD;
      cfg.alert_hold_ms   = RST_ALERT_HOLD;
      cfg.short_hold_ms   = RST_SHORT_HOLD;
      cfg.overcur_hold_ms = RST_OVERCUR_HOLD;
      cfg.short_limit     = RST_SHORT_LIMIT;
      cfg.overcur_limit   = RST_OVERCUR_LIMIT;
      clear_timers();
   endfunction

   // Arms an idle timer, or reports and disarms one whose hold has run out.
   function automatic bit hold_elapsed(int t, logic [TIME_W-1:0] now,
                                       logic [HOLD_W-1:0] hold);
      logic [TIME_W-1:0] waited;
      if (!tmr_armed[t]) begin
         tmr_armed[t] = 1'b1;
         tmr_start[t] = now;
         return 1'b0;
      end
      waited = now - tmr_start[t];
      if (waited >= TIME_W'(hold)) begin
         tmr_armed[t] = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the verdict for one poll and advances the timers and counters.
   function automatic verdict_type judge_poll(poll_type p);
      verdict_type v;
      bit          in_limits;
      bit          shut;
      v.mask = '0;
      v.cmd  = CMD_NONE;
      shut   = 1'b0;
      if (p.flags == FL_NONE) begin
         clear_timers();
         in_limits = !p.conn ||
                     (p.vmin >= cfg.undervolt_mv && p.vmax <= cfg.overvolt_mv);
         v.cmd = (in_limits && !p.dis_on) ? CMD_ENABLE : CMD_NONE;
      end else begin
         v.cmd = CMD_DISABLE;
         if (p.flags[F_READY] && hold_elapsed(TMR_READY, p.now, cfg.ready_hold_ms))
            v.mask[F_READY] = 1'b1;
         if (p.flags[F_ALERT] && hold_elapsed(TMR_ALERT, p.now, cfg.alert_hold_ms))
            v.mask[F_ALERT] = 1'b1;
         if (p.flags[F_UV] && p.conn && p.vmin > cfg.undervolt_mv)
            v.mask[F_UV] = 1'b1;
         if (p.flags[F_OV] && p.vmax < cfg.overvolt_mv)
            v.mask[F_OV] = 1'b1;
         if (p.flags[F_SHORT]) begin
            if (hold_elapsed(TMR_SHORT, p.now, cfg.short_hold_ms)) begin
               v.mask[F_SHORT] = 1'b1;
               if (short_cnt != CNT_MAX) short_cnt = short_cnt + 1'b1;
            end
            if (short_cnt == cfg.short_limit) shut = 1'b1;
         end
         if (p.flags[F_OVERCUR]) begin
            if (hold_elapsed(TMR_OVERCUR, p.now, cfg.overcur_hold_ms)) begin
               v.mask[F_OVERCUR] = 1'b1;
               if (overcur_cnt != CNT_MAX) overcur_cnt = overcur_cnt + 1'b1;
            end
            if (overcur_cnt == cfg.overcur_limit) shut = 1'b1;
         end
      end
      v.shut_self = shut;
      v.shut_peer = shut;
      return v;
   endfunction

   // Register write on the csr channel; the predictor's copy follows it.
   task automatic write_reg(reg_idx_type idx, logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_UNDERVOLT:     cfg.undervolt_mv    = data[MV_W-1:0];
         REG_OVERVOLT:      cfg.overvolt_mv     = data[MV_W-1:0];
         REG_READY_HOLD:    cfg.ready_hold_ms   = data[HOLD_W-1:0];
         REG_ALERT_HOLD:    cfg.alert_hold_ms   = data[HOLD_W-1:0];
         REG_SHORT_HOLD:    cfg.short_hold_ms   = data[HOLD_W-1:0];
         REG_OVERCUR_HOLD:  cfg.overcur_hold_ms = data[HOLD_W-1:0];
         REG_SHORT_LIMIT:   cfg.short_limit     = data[CNT_W-1:0];
         REG_OVERCUR_LIMIT: cfg.overcur_limit   = data[CNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_poll(logic [FLAG_W-1:0] flags, logic [TIME_W-1:0] now,
                           logic [MV_W-1:0] vmin, logic [MV_W-1:0] vmax,
                           logic conn, logic dis_on);
      poll_type p;
      p.flags  = flags;
      p.now    = now;
      p.vmin   = vmin;
      p.vmax   = vmax;
      p.conn   = conn;
      p.dis_on = dis_on;
      polls_pending.push_back(p);
   endtask

   // Random polls: time mostly runs forward and flags persist, so holds run
   // out and retry counters climb. In hammer mode short and overcurrent stay
   // set on every poll so the counters can reach saturation.
   task automatic queue_random(int n, bit hammer);
      poll_type          p;
      int                i;
      int                pick;
      int                bit_sel;
      logic [HOLD_W-1:0] hold_step;
      logic [MV_W-1:0]   jitter;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            gen_ms = gen_ms + $urandom_range(0, 40);
         end else if (pick < 7) begin
            gen_ms = gen_ms + $urandom_range(0, 70000);
         end else if (pick < 9) begin
            // Land on or just short of a hold boundary.
            case ($urandom_range(0, 3))
               0: hold_step = cfg.ready_hold_ms;
               1: hold_step = cfg.alert_hold_ms;
               2: hold_step = cfg.short_hold_ms;
               default: hold_step = cfg.overcur_hold_ms;
            endcase
            gen_ms = gen_ms + hold_step - $urandom_range(0, 1);
         end else begin
            gen_ms = $urandom;
         end

         pick = $urandom_range(0, 15);
         if (hammer) begin
            gen_flags = FLAG_W'($urandom_range(0, 63)) | FL_SHORT | FL_OVERCUR;
         end else if (pick == 0) begin
            gen_flags = FL_NONE;
         end else if (pick == 1) begin
            gen_flags = FLAG_W'($urandom_range(0, 63));
         end else if (pick < 7) begin
            bit_sel = $urandom_range(0, FLAG_W - 1);
            gen_flags[bit_sel] = ~gen_flags[bit_sel];
         end

         p.flags = gen_flags;
         p.now   = gen_ms;
         jitter  = MV_W'($urandom_range(0, 4));
         if ($urandom_range(0, 3) == 0) p.vmin = MV_W'($urandom_range(0, 8191));
         else p.vmin = MV_W'(cfg.undervolt_mv + jitter - 2);
         jitter  = MV_W'($urandom_range(0, 4));
         if ($urandom_range(0, 3) == 0) p.vmax = MV_W'($urandom_range(0, 8191));
         else p.vmax = MV_W'(cfg.overvolt_mv + jitter - 2);
         p.conn   = ($urandom_range(0, 3) != 0);
         p.dis_on = 1'($urandom_range(0, 1));
         polls_pending.push_back(p);
      end
   endtask

   // Waits until every poll is out and every verdict has come back.
   task automatic wait_idle();
      while (polls_pending.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Poll driver: bursts of beats with random gaps, payload held while stalled.
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset || (req_valid && !poll_taken)) begin
         // Keep the current beat on the bus.
      end else begin
         poll_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (polls_pending.size() != 0) begin
            cur_poll = polls_pending.pop_front();
            req_valid         <= 1'b1;
            req_status_flags  <= cur_poll.flags;
            req_now_ms        <= cur_poll.now;
            req_min_cell_mv   <= cur_poll.vmin;
            req_max_cell_mv   <= cur_poll.vmax;
            req_has_connected <= cur_poll.conn;
            req_discharge_on  <= cur_poll.dis_on;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               if (calm || $urandom_range(0, 2) == 0) gap_left = 0;
               else gap_left = $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: a 16-bit pattern stepped through bit by bit, redrawn each time it runs out.
   logic [15:0] stall_pat = '0;
   logic [3:0]  stall_pos = '0;
   always @(negedge clock) begin
      if (stall_pos == 4'd0) begin
         case ($urandom_range(0, 3))
            0: stall_pat = '0;
            1: stall_pat = 16'($urandom & $urandom);
            2: stall_pat = 16'($urandom);
            default: stall_pat = 16'($urandom | $urandom);
         endcase
         if (calm) stall_pat = '0;
      end
      rsp_stall <= stall_pat[stall_pos];
      stall_pos = stall_pos + 1'b1;
   end

   // Verdict check first, then prediction for a poll accepted at this edge.
   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            $error("verdict beat with no poll outstanding");
            err_count++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_clear_mask !== want.mask) begin
               $error("clear_mask: expected %0h, actual %0h", want.mask, rsp_clear_mask);
               err_count++;
            end
            if (rsp_discharge_cmd !== want.cmd) begin
               $error("discharge_cmd: expected %0d, actual %0d", want.cmd,
                      rsp_discharge_cmd);
               err_count++;
            end
            if (rsp_shutdown_self !== want.shut_self) begin
               $error("shutdown_self: expected %0b, actual %0b", want.shut_self,
                      rsp_shutdown_self);
               err_count++;
            end
            if (rsp_shutdown_peer !== want.shut_peer) begin
               $error("shutdown_peer: expected %0b, actual %0b", want.shut_peer,
                      rsp_shutdown_peer);
               err_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         verdicts_due.push_back(judge_poll(cur_poll));
         poll_taken = 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Test sequence.
   initial begin
      model_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed polls under the reset configuration.
      // No flag: enable only with discharge off and no cells or every cell within limits.
      add_poll(FL_NONE, 32'd0, 13'd0, 13'd0, 1'b0, 1'b0);
      add_poll(FL_NONE, 32'd5, 13'd3000, 13'd4200, 1'b1, 1'b0);
      add_poll(FL_NONE, 32'd6, 13'd2999, 13'd4200, 1'b1, 1'b0);
      add_poll(FL_NONE, 32'd7, 13'd3000, 13'd4201, 1'b1, 1'b0);
      add_poll(FL_NONE, 32'd8, 13'd3500, 13'd3600, 1'b1, 1'b1);
      // Every flag at time zero arms every timer.
      add_poll(FL_ALL, 32'd0, 13'd8191, 13'd0, 1'b1, 1'b1);
      // Undervolt with no connected cell stays; overvolt at the limit stays.
      add_poll(FL_ALL, 32'd2999, 13'd8191, 13'd4200, 1'b0, 1'b0);
      add_poll(FL_ALL, 32'd3000, 13'd3000, 13'd4199, 1'b1, 1'b0);
      // Flags left clear keep their timers while others are set.
      add_poll(FL_ALERT | FL_OVERCUR, 32'd10000, 13'd100, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT, 32'd29999, 13'd100, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT, 32'd30000, 13'd100, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT, 32'd40000, 13'd100, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT, 32'd70000, 13'd100, 13'd100, 1'b1, 1'b0);
      // Short timer across the wrap of the millisecond time, up to the limit.
      add_poll(FL_SHORT, 32'hFFFF_FFF0, 13'd100, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT | FL_UV, 32'h0000_751F, 13'd3001, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT, 32'h0000_7520, 13'd100, 13'd100, 1'b1, 1'b0);
      add_poll(FL_SHORT | FL_READY, 32'hFFFF_FFFF, 13'd100, 13'd100, 1'b1, 1'b1);
      add_poll(FL_OVERCUR, 32'hFFFF_FFFF, 13'd8191, 13'd8191, 1'b1, 1'b0);
      // No flag clears everything; a fresh timer may start at time zero.
      add_poll(FL_NONE, 32'd0, 13'd8191, 13'd8191, 1'b1, 1'b0);
      add_poll(FL_SHORT, 32'd0, 13'd0, 13'd8191, 1'b0, 1'b1);
      add_poll(FL_SHORT, 32'd0, 13'd0, 13'd8191, 1'b1, 1'b1);
      add_poll(FL_ALL, 32'd65535, 13'd0, 13'd8191, 1'b1, 1'b0);
      wait_idle();

      queue_random(140, 1'b0);
      wait_idle();

      // Low extremes, upper data bits set to check the field widths.
      calm = 1'b1;
      write_reg(REG_UNDERVOLT, 16'hE000);
      write_reg(REG_OVERVOLT, 16'h1FFF);
      write_reg(REG_READY_HOLD, 16'h0000);
      write_reg(REG_ALERT_HOLD, 16'h0000);
      write_reg(REG_SHORT_HOLD, 16'h0000);
      write_reg(REG_OVERCUR_HOLD, 16'h0000);
      write_reg(REG_SHORT_LIMIT, 16'h0100);
      write_reg(REG_OVERCUR_LIMIT, 16'h0001);
      queue_random(120, 1'b0);
      wait_idle();
      calm = 1'b0;

      // High extremes.
      write_reg(REG_UNDERVOLT, 16'h1FFF);
      write_reg(REG_OVERVOLT, 16'hE000);
      write_reg(REG_READY_HOLD, 16'hFFFF);
      write_reg(REG_ALERT_HOLD, 16'hFFFF);
      write_reg(REG_SHORT_HOLD, 16'hFFFF);
      write_reg(REG_OVERCUR_HOLD, 16'hFFFF);
      write_reg(REG_SHORT_LIMIT, 16'hFFFF);
      write_reg(REG_OVERCUR_LIMIT, 16'h00FF);
      queue_random(100, 1'b0);
      wait_idle();

      // Zero holds and top limits: counters run into saturation.
      write_reg(REG_UNDERVOLT, 16'd3000);
      write_reg(REG_OVERVOLT, 16'd4200);
      write_reg(REG_SHORT_HOLD, 16'h0000);
      write_reg(REG_OVERCUR_HOLD, 16'h0000);
      write_reg(REG_SHORT_LIMIT, 16'd255);
      write_reg(REG_OVERCUR_LIMIT, 16'd254);
      queue_random(540, 1'b1);
      wait_idle();

      // Random settings with short holds and small limits.
      write_reg(REG_UNDERVOLT, DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_OVERVOLT, DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_READY_HOLD, DATA_W'($urandom_range(0, 3000)));
      write_reg(REG_ALERT_HOLD, DATA_W'($urandom_range(0, 3000)));
      write_reg(REG_SHORT_HOLD, DATA_W'($urandom_range(0, 3000)));
      write_reg(REG_OVERCUR_HOLD, DATA_W'($urandom_range(0, 3000)));
      write_reg(REG_SHORT_LIMIT,
                DATA_W'(($urandom_range(0, 255) << 8) | $urandom_range(1, 4)));
      write_reg(REG_OVERCUR_LIMIT,
                DATA_W'(($urandom_range(0, 255) << 8) | $urandom_range(1, 4)));
      queue_random(100, 1'b0);
      wait_idle();

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
